>>> sv/oidq_pkg.sv
// Package for the ordered id list queue: command and response beat types,
// opcode and status codes, and the sequencer state type.
// No dependencies; the top level and the sequencer import it.
package oidq_pkg;

  localparam int ID_W       = 32;
  localparam int OPC_W      = 4;
  localparam int POS_W      = 8;
  localparam int STAT_W     = 3;
  localparam int FIDX_W     = 7;
  localparam int CNT_W      = 8;
  localparam int OIDQ_DEPTH = 128;

  localparam logic [OPC_W-1:0] OP_PUSH       = 4'd0;
  localparam logic [OPC_W-1:0] OP_POP        = 4'd1;
  localparam logic [OPC_W-1:0] OP_PEEK       = 4'd2;
  localparam logic [OPC_W-1:0] OP_READ_AT    = 4'd3;
  localparam logic [OPC_W-1:0] OP_FIND       = 4'd4;
  localparam logic [OPC_W-1:0] OP_REMOVE_ALL = 4'd5;
  localparam logic [OPC_W-1:0] OP_REMOVE_AT  = 4'd6;
  localparam logic [OPC_W-1:0] OP_INSERT_AT  = 4'd7;
  localparam logic [OPC_W-1:0] OP_CLEAR      = 4'd8;

  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 3'd4;

  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic [ID_W-1:0]  track_id;
    logic [POS_W-1:0] position;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [FIDX_W-1:0] found_index;
    logic [ID_W-1:0]   entry_value;
    logic [CNT_W-1:0]  removed_count;
    logic [CNT_W-1:0]  entry_count;
  } rsp_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_FINISH,
    SEQ_RESP
  } seq_state_t;

endpackage

>>> sv/ordered_id_list_queue.sv
// Top level of the ordered id list queue: command sequencer plus the
// response output register. Depends on oidq_pkg, oidq_seq and oidq_mem.
//
//   Beat      Direction  Handshake              Payload
//   command   in         cmd_valid / cmd_ready  cmd (cmd_t)
//   response  out        rsp_valid / rsp_ready  rsp (rsp_t)
//
// Push, clear, unknown opcodes and every rejected command go from idle
// straight to the response state. Peek and read_at read one entry; pop,
// find, remove_all, remove_at and insert_at walk N entries. These pass
// the scan state, then the finish state; the entry store moves one entry
// per cycle through its single read port and single write port.
// Reset empties the list at once; no clearing pass is needed since only
// entries below the count are ever read.
// A finished response waits in the output register while the next command
// beat is accepted; the sequencer holds its own result only if that
// register is still occupied.
module ordered_id_list_queue
  import oidq_pkg::*;
#(
  parameter int DEPTH = OIDQ_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic slot_free;
  logic rsp_load;
  rsp_t rsp_next;

  // The output register is free when it is empty or being drained this cycle.
  assign slot_free = !rsp_valid || rsp_ready;

  oidq_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .slot_free(slot_free),
    .rsp_load (rsp_load),
    .rsp_next (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Payload register; it only changes when a new response is loaded.
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule

>>> sv/oidq_mem.sv
// Entry store of the ordered id list queue: one write port and one read
// port, read data registered. Depends on nothing but its parameters.
module oidq_mem #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/oidq_seq.sv
// Command sequencer of the ordered id list queue: decodes a command, walks
// the entry store one entry per cycle and builds the response.
// Depends on oidq_pkg and oidq_mem.
module oidq_seq
  import oidq_pkg::*;
#(
  parameter int DEPTH = OIDQ_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  input  logic slot_free,
  output logic rsp_load,
  output rsp_t rsp_next
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  seq_state_t        state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [OPC_W-1:0]  op, op_next;
  logic [ID_W-1:0]   id, id_next;
  logic [AW-1:0]     pos_idx, pos_idx_next;
  logic [AW-1:0]     rd_idx, rd_idx_next;
  logic [CW-1:0]     rd_left, rd_left_next;
  logic              rd_down, rd_down_next;
  logic              rv, rv_next;
  logic [AW-1:0]     r_idx, r_idx_next;
  logic              rfirst, rfirst_next;
  logic [CW-1:0]     wr_ptr, wr_ptr_next;
  logic [CW-1:0]     removed, removed_next;
  logic              found, found_next;
  logic [AW-1:0]     found_idx, found_idx_next;
  logic [ID_W-1:0]   value, value_next;
  logic [STAT_W-1:0] status, status_next;

  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [ID_W-1:0]   mem_wd;
  logic              mem_re;
  logic [AW-1:0]     mem_ra;
  logic [ID_W-1:0]   mem_rd;

  logic [XW-1:0]     posx, cntx;
  logic              is_full, is_empty, bad_read, bad_insert;

  oidq_mem #(
    .DEPTH(DEPTH),
    .WIDTH(ID_W)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_wa),
    .wr_data(mem_wd),
    .rd_en  (mem_re),
    .rd_addr(mem_ra),
    .rd_data(mem_rd)
  );

  assign posx       = XW'(cmd.position);
  assign cntx       = XW'(count);
  assign is_full    = (count == CW'(DEPTH));
  assign is_empty   = (count == '0);
  assign bad_read   = (posx >= cntx);
  assign bad_insert = (posx > cntx);

  always_comb begin
    rsp_next.status        = status;
    rsp_next.found_index   = FIDX_W'(found_idx);
    rsp_next.entry_value   = value;
    rsp_next.removed_count = CNT_W'(removed);
    rsp_next.entry_count   = CNT_W'(count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      count <= '0;
      rv    <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rv    <= rv_next;
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    id        <= id_next;
    pos_idx   <= pos_idx_next;
    rd_idx    <= rd_idx_next;
    rd_left   <= rd_left_next;
    rd_down   <= rd_down_next;
    r_idx     <= r_idx_next;
    rfirst    <= rfirst_next;
    wr_ptr    <= wr_ptr_next;
    removed   <= removed_next;
    found     <= found_next;
    found_idx <= found_idx_next;
    value     <= value_next;
    status    <= status_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    op_next        = op;
    id_next        = id;
    pos_idx_next   = pos_idx;
    rd_idx_next    = rd_idx;
    rd_left_next   = rd_left;
    rd_down_next   = rd_down;
    rv_next        = 1'b0;
    r_idx_next     = r_idx;
    rfirst_next    = rfirst;
    wr_ptr_next    = wr_ptr;
    removed_next   = removed;
    found_next     = found;
    found_idx_next = found_idx;
    value_next     = value;
    status_next    = status;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = id;
    mem_re         = 1'b0;
    mem_ra         = rd_idx;
    cmd_ready      = 1'b0;
    rsp_load       = 1'b0;

    unique case (state)
      SEQ_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          op_next        = cmd.opcode;
          id_next        = cmd.track_id;
          pos_idx_next   = AW'(posx);
          status_next    = STAT_OK;
          found_next     = 1'b0;
          found_idx_next = '0;
          value_next     = '0;
          removed_next   = '0;
          wr_ptr_next    = '0;
          rfirst_next    = 1'b1;
          rd_down_next   = 1'b0;
          rd_left_next   = '0;
          rd_idx_next    = '0;
          state_next     = SEQ_RESP;
          case (cmd.opcode)
            OP_PUSH: begin
              if (is_full) begin
                status_next = STAT_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_wa     = AW'(count);
                mem_wd     = cmd.track_id;
                count_next = count + CW'(1);
              end
            end
            OP_POP, OP_PEEK: begin
              if (is_empty) begin
                status_next = STAT_EMPTY;
              end else begin
                rd_left_next = (cmd.opcode == OP_POP) ? count : CW'(1);
                state_next   = SEQ_SCAN;
              end
            end
            OP_READ_AT: begin
              if (bad_read) begin
                status_next = STAT_BAD_INDEX;
              end else begin
                rd_left_next = CW'(1);
                rd_idx_next  = AW'(posx);
                state_next   = SEQ_SCAN;
              end
            end
            OP_FIND, OP_REMOVE_ALL: begin
              rd_left_next = count;
              state_next   = SEQ_SCAN;
            end
            OP_REMOVE_AT: begin
              if (bad_read) begin
                status_next = STAT_BAD_INDEX;
              end else begin
                rd_left_next = CW'(cntx - posx);
                rd_idx_next  = AW'(posx);
                state_next   = SEQ_SCAN;
              end
            end
            OP_INSERT_AT: begin
              if (is_full) begin
                status_next = STAT_FULL;
              end else if (bad_insert) begin
                status_next = STAT_BAD_INDEX;
              end else begin
                rd_left_next = CW'(cntx - posx);
                rd_idx_next  = AW'(cntx - XW'(1));
                rd_down_next = 1'b1;
                state_next   = SEQ_SCAN;
              end
            end
            OP_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end

      SEQ_SCAN: begin
        // Issue one read per cycle; handle the entry read in the cycle before.
        if (rd_left != '0) begin
          mem_re       = 1'b1;
          rd_idx_next  = rd_down ? (rd_idx - AW'(1)) : (rd_idx + AW'(1));
          rd_left_next = rd_left - CW'(1);
          rv_next      = 1'b1;
          r_idx_next   = rd_idx;
        end
        if (rv) begin
          rfirst_next = 1'b0;
          case (op)
            OP_POP, OP_PEEK, OP_READ_AT, OP_REMOVE_AT: begin
              if (rfirst) begin
                if (op != OP_REMOVE_AT) begin
                  value_next = mem_rd;
                end
              end else begin
                mem_we = 1'b1;
                mem_wa = r_idx - AW'(1);
                mem_wd = mem_rd;
              end
            end
            OP_FIND: begin
              if (mem_rd == id && !found) begin
                found_next     = 1'b1;
                found_idx_next = r_idx;
              end
            end
            OP_REMOVE_ALL: begin
              if (mem_rd == id) begin
                removed_next = removed + CW'(1);
              end else begin
                mem_we      = 1'b1;
                mem_wa      = AW'(wr_ptr);
                mem_wd      = mem_rd;
                wr_ptr_next = wr_ptr + CW'(1);
              end
            end
            OP_INSERT_AT: begin
              mem_we = 1'b1;
              mem_wa = r_idx + AW'(1);
              mem_wd = mem_rd;
            end
            default: begin
            end
          endcase
        end
        if (rd_left == '0 && !rv) begin
          state_next = SEQ_FINISH;
        end
      end

      SEQ_FINISH: begin
        state_next = SEQ_RESP;
        case (op)
          OP_POP, OP_REMOVE_AT: begin
            count_next = count - CW'(1);
          end
          OP_FIND: begin
            if (!found) begin
              status_next = STAT_NOT_FOUND;
            end
          end
          OP_REMOVE_ALL: begin
            count_next = wr_ptr;
            if (removed == '0) begin
              status_next = STAT_NOT_FOUND;
            end
          end
          OP_INSERT_AT: begin
            mem_we     = 1'b1;
            mem_wa     = pos_idx;
            mem_wd     = id;
            count_next = count + CW'(1);
          end
          default: begin
          end
        endcase
      end

      SEQ_RESP: begin
        if (slot_free) begin
          rsp_load   = 1'b1;
          state_next = SEQ_IDLE;
        end
      end

      default: begin
        state_next = SEQ_IDLE;
      end
    endcase
  end

endmodule
